### rtl/core/iptl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iptl_pkg
// Types and constants for the binary trie prefix lookup block.
// ----------------------------------------------------------------------------
package iptl_pkg;

  localparam int unsigned MaxNodes   = 65536;
  localparam int unsigned StoreDepth = (MaxNodes < 65536) ? MaxNodes : 65536;
  localparam int unsigned NodeAw     = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  localparam logic [7:0] MaxDepth = 8'd128;

  localparam logic [3:0] RecBytes24 = 4'd6;
  localparam logic [3:0] RecBytes28 = 4'd7;
  localparam logic [3:0] RecBytes32 = 4'd8;

  localparam logic [1:0] RegTrieSize    = 2'd0;
  localparam logic [1:0] RegRecordBytes = 2'd1;
  localparam logic [1:0] RegTreeDepth   = 2'd2;

  localparam logic [16:0] TrieSizeRst    = 17'd1;
  localparam logic [3:0]  RecordBytesRst = 4'd6;
  localparam logic [7:0]  TreeDepthRst   = 8'd128;

  localparam logic OpWrite  = 1'b0;
  localparam logic OpLookup = 1'b1;

  localparam logic StatusFound   = 1'b0;
  localparam logic StatusCorrupt = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] node_index;
    logic [63:0] node_bytes;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } item_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  netmask;
    logic [31:0] data_offset;
  } result_t;

  typedef struct packed {
    logic [16:0] trie_size;
    logic [3:0]  record_bytes;
    logic [7:0]  tree_depth;
  } cfg_t;

endpackage

### rtl/core/iptl_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iptl_cfg_regs
// APB register file: node count, record size and tree depth.
// ----------------------------------------------------------------------------
module iptl_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output iptl_pkg::cfg_t      cfg_o
);

  logic [16:0] trie_size_q, trie_size_d;
  logic [3:0]  record_bytes_q, record_bytes_d;
  logic [7:0]  tree_depth_q, tree_depth_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    trie_size_d    = trie_size_q;
    record_bytes_d = record_bytes_q;
    tree_depth_d   = tree_depth_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        iptl_pkg::RegTrieSize:    trie_size_d    = pwdata[16:0];
        iptl_pkg::RegRecordBytes: record_bytes_d = pwdata[3:0];
        iptl_pkg::RegTreeDepth:   tree_depth_d   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      iptl_pkg::RegTrieSize:    prdata = {15'd0, trie_size_q};
      iptl_pkg::RegRecordBytes: prdata = {28'd0, record_bytes_q};
      iptl_pkg::RegTreeDepth:   prdata = {24'd0, tree_depth_q};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trie_size_q    <= iptl_pkg::TrieSizeRst;
      record_bytes_q <= iptl_pkg::RecordBytesRst;
      tree_depth_q   <= iptl_pkg::TreeDepthRst;
    end else begin
      trie_size_q    <= trie_size_d;
      record_bytes_q <= record_bytes_d;
      tree_depth_q   <= tree_depth_d;
    end
  end

  assign cfg_o.trie_size    = trie_size_q;
  assign cfg_o.record_bytes = record_bytes_q;
  assign cfg_o.tree_depth   = tree_depth_q;

endmodule

### rtl/core/ip_prefix_trie_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_prefix_trie_lookup
// Longest-prefix-match lookup over a binary trie held in a node memory.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A node write is done in the
// accept cycle; busy stays low and a new word may follow at once. A lookup walks
// the trie one level per cycle, one node memory read per level, at most
// min(tree_depth,128) levels; busy is high while it walks, and the result shows
// on done_o for one cycle as busy falls. A bad record size or a zero depth
// answers corrupt the cycle after accept. Results cannot be held off.
// The node memory has no reset; nodes must be written before a walk reads them.
// ----------------------------------------------------------------------------
module ip_prefix_trie_lookup (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  iptl_pkg::item_t      item_i,
  output logic                 done_o,
  output iptl_pkg::result_t    result_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  typedef enum logic {
    StIdle,
    StWalk
  } state_e;

  iptl_pkg::cfg_t cfg;

  iptl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [63:0] mem [iptl_pkg::StoreDepth];
  logic [63:0] rd_data_q;

  state_e            state_q, state_d;
  logic [7:0]        level_q, level_d;
  logic [7:0]        depth_q, depth_d;
  logic              oob_q, oob_d;
  logic              done_q, done_d;
  iptl_pkg::result_t result_q, result_d;
  logic [127:0]      addr_q;

  logic                        accept;
  logic                        mem_we;
  logic                        mem_re;
  logic [iptl_pkg::NodeAw-1:0] rd_addr;
  logic [7:0]                  depth_eff;
  logic                        rb_ok;
  logic [63:0]                 node;
  logic [6:0]                  bit_idx;
  logic                        dir;
  logic [31:0]                 rec;
  logic                        hit;

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);
  assign mem_we = accept && (item_i.op == iptl_pkg::OpWrite) &&
                  (32'(item_i.node_index) < 32'(iptl_pkg::StoreDepth));

  assign depth_eff = (cfg.tree_depth > iptl_pkg::MaxDepth) ? iptl_pkg::MaxDepth
                                                           : cfg.tree_depth;
  assign rb_ok = (cfg.record_bytes == iptl_pkg::RecBytes24) ||
                 (cfg.record_bytes == iptl_pkg::RecBytes28) ||
                 (cfg.record_bytes == iptl_pkg::RecBytes32);

  assign node    = oob_q ? 64'd0 : rd_data_q;
  assign bit_idx = 7'(level_q - 8'd1);
  assign dir     = addr_q[bit_idx];

  always_comb begin
    case (cfg.record_bytes)
      iptl_pkg::RecBytes24:
        rec = dir ? {8'd0, node[23:0]} : {8'd0, node[47:24]};
      iptl_pkg::RecBytes28:
        rec = dir ? {4'd0, node[27:0]} : {4'd0, node[31:28], node[55:32]};
      default:
        rec = dir ? node[31:0] : node[63:32];
    endcase
  end

  assign hit = (rec >= 32'(cfg.trie_size));

  always_comb begin
    state_d  = state_q;
    level_d  = level_q;
    depth_d  = depth_q;
    oob_d    = oob_q;
    done_d   = 1'b0;
    result_d = result_q;
    mem_re   = 1'b0;
    rd_addr  = '0;
    unique case (state_q)
      StIdle: begin
        if (accept && (item_i.op == iptl_pkg::OpLookup)) begin
          if (!rb_ok || (depth_eff == 8'd0)) begin
            done_d   = 1'b1;
            result_d = '{status: iptl_pkg::StatusCorrupt, netmask: 8'd0,
                         data_offset: 32'd0};
          end else begin
            mem_re  = 1'b1;
            oob_d   = 1'b0;
            level_d = depth_eff;
            depth_d = depth_eff;
            state_d = StWalk;
          end
        end
      end
      StWalk: begin
        if (hit) begin
          done_d   = 1'b1;
          result_d = '{status: iptl_pkg::StatusFound,
                       netmask: 8'(depth_q - level_q + 8'd1),
                       data_offset: rec - 32'(cfg.trie_size)};
          state_d  = StIdle;
        end else if (level_q == 8'd1) begin
          done_d   = 1'b1;
          result_d = '{status: iptl_pkg::StatusCorrupt, netmask: 8'd0,
                       data_offset: 32'd0};
          state_d  = StIdle;
        end else begin
          mem_re  = 1'b1;
          rd_addr = rec[iptl_pkg::NodeAw-1:0];
          oob_d   = (rec >= 32'(iptl_pkg::StoreDepth));
          level_d = level_q - 8'd1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[item_i.node_index[iptl_pkg::NodeAw-1:0]] <= item_i.node_bytes;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (item_i.op == iptl_pkg::OpLookup)) begin
      addr_q <= {item_i.addr_high, item_i.addr_low};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      level_q  <= 8'd0;
      depth_q  <= 8'd0;
      oob_q    <= 1'b0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      state_q  <= state_d;
      level_q  <= level_d;
      depth_q  <= depth_d;
      oob_q    <= oob_d;
      done_q   <= done_d;
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  a_write_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.op == iptl_pkg::OpWrite)) |=> !busy)
    else $error("node write stalled the block");

  a_walk_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> (level_q != 8'd0) && (level_q <= depth_q))
    else $error("walk level out of range");

  a_corrupt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == iptl_pkg::StatusCorrupt)) |->
      (result_o.netmask == 8'd0) && (result_o.data_offset == 32'd0))
    else $error("corrupt result carries data");

  a_found_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == iptl_pkg::StatusFound)) |->
      (result_o.netmask != 8'd0) && (result_o.netmask <= iptl_pkg::MaxDepth))
    else $error("found result with bad netmask");

  a_done_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(state_q == StWalk)) |-> !busy)
    else $error("result shown while still walking");

endmodule

### verif/ip_prefix_trie_lookup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_prefix_trie_lookup_tb
// Self-checking bench for the binary trie prefix lookup block. Node words
// build small tries that are random but well formed. Lookup words walk those
// tries. A scoreboard keeps its own copy of the node store and of the
// registers, predicts every lookup and compares each result strobe with the
// oldest prediction. A directed part covers each record size, bad sizes,
// zero and oversized depth, a zero node count and pointers past the store.
// Random phases then vary the registers and the sender gaps.
// ----------------------------------------------------------------------------
module ip_prefix_trie_lookup_tb;

  class trie_scoreboard;
    bit [63:0]         nodes [iptl_pkg::MaxNodes];
    bit [16:0]         trie_size;
    bit [3:0]          record_bytes;
    bit [7:0]          tree_depth;
    iptl_pkg::result_t lookup_q[$];
    int unsigned       errors;

    function new();
      trie_size    = iptl_pkg::TrieSizeRst;
      record_bytes = iptl_pkg::RecordBytesRst;
      tree_depth   = iptl_pkg::TreeDepthRst;
      errors       = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        iptl_pkg::RegTrieSize:    trie_size    = val[16:0];
        iptl_pkg::RegRecordBytes: record_bytes = val[3:0];
        iptl_pkg::RegTreeDepth:   tree_depth   = val[7:0];
        default: ;
      endcase
    endfunction

    function void flag(string what, logic [63:0] exp_val, logic [63:0] act_val);
      errors++;
      if (errors <= 10)
        $display("%0t mismatch, %s: expected %0h, got %0h", $time, what, exp_val, act_val);
    endfunction

    function int unsigned pending();
      return lookup_q.size();
    endfunction

    function bit [31:0] node_record(bit [63:0] node, bit right);
      case (record_bytes)
        iptl_pkg::RecBytes24:
          return right ? {8'h0, node[23:0]} : {8'h0, node[47:24]};
        iptl_pkg::RecBytes28:
          return right ? {4'h0, node[27:0]} : {4'h0, node[31:28], node[55:32]};
        default:
          return right ? node[31:0] : node[63:32];
      endcase
    endfunction

    function iptl_pkg::result_t walk_trie(iptl_pkg::item_t w);
      iptl_pkg::result_t res;
      bit [127:0]        addr;
      bit [63:0]         node;
      bit [31:0]         rec;
      bit [31:0]         cur;
      int unsigned       depth;
      int unsigned       b;
      res = '0;
      res.status = iptl_pkg::StatusCorrupt;
      if (record_bytes < iptl_pkg::RecBytes24 || record_bytes > iptl_pkg::RecBytes32)
        return res;
      depth = 32'((tree_depth > iptl_pkg::MaxDepth) ? iptl_pkg::MaxDepth : tree_depth);
      addr  = {w.addr_high, w.addr_low};
      cur   = '0;
      for (int lvl = int'(depth); lvl > 0; lvl--) begin
        b    = 32'(lvl - 1);
        node = (cur < iptl_pkg::MaxNodes) ? nodes[16'(cur)] : '0;
        rec  = node_record(node, addr[7'(b)]);
        if (rec >= {15'b0, trie_size}) begin
          res.status      = iptl_pkg::StatusFound;
          res.netmask     = 8'(depth - b);
          res.data_offset = rec - {15'b0, trie_size};
          return res;
        end
        cur = rec;
      end
      return res;
    endfunction

    function void note_word(iptl_pkg::item_t w);
      if (w.op == iptl_pkg::OpWrite) nodes[w.node_index] = w.node_bytes;
      else lookup_q.push_back(walk_trie(w));
    endfunction

    function void check_result(iptl_pkg::result_t got);
      iptl_pkg::result_t want;
      if (lookup_q.size() == 0) begin
        flag("result with nothing pending", '0, 64'(got));
        return;
      end
      want = lookup_q.pop_front();
      if (got.status !== want.status)
        flag("status", 64'(want.status), 64'(got.status));
      if (got.netmask !== want.netmask)
        flag("netmask", 64'(want.netmask), 64'(got.netmask));
      if (got.data_offset !== want.data_offset)
        flag("data_offset", 64'(want.data_offset), 64'(got.data_offset));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni  = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  iptl_pkg::item_t   item_i  = '0;
  logic              done_o;
  iptl_pkg::result_t result_o;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [3:0]        paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  trie_scoreboard sb = new();

  bit [16:0]   cur_nc;
  bit [3:0]    cur_rb;
  int unsigned tree_nodes;
  int unsigned idle_pct;

  ip_prefix_trie_lookup i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("[ip_prefix_trie_lookup] ERROR");
    $finish;
  end

  // results first: a result at an edge always belongs to an older lookup
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(result_o);
      if (start && !busy) sb.note_word(item_i);
    end
  end

  function automatic bit [31:0] record_limit(bit [3:0] rb);
    case (rb)
      iptl_pkg::RecBytes24: return 32'h00FF_FFFF;
      iptl_pkg::RecBytes28: return 32'h0FFF_FFFF;
      default:              return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic bit [31:0] pick_child(int unsigned leaf_pct);
    bit [31:0] top;
    top = record_limit(cur_rb);
    if ($urandom_range(99) >= leaf_pct) return $urandom_range(tree_nodes - 1);
    case ($urandom_range(7))
      0:       return 32'(cur_nc);
      1:       return top;
      default: return 32'(cur_nc) + $urandom_range(top - 32'(cur_nc));
    endcase
  endfunction

  function automatic bit [63:0] pack_node(bit [31:0] left, bit [31:0] right);
    bit [63:0] node;
    node = {$urandom, $urandom};
    case (cur_rb)
      iptl_pkg::RecBytes24: node[47:0] = {left[23:0], right[23:0]};
      iptl_pkg::RecBytes28: begin
        node[55:32] = left[23:0];
        node[31:28] = left[27:24];
        node[27:0]  = right[27:0];
      end
      default: node = {left, right};
    endcase
    return node;
  endfunction

  function automatic iptl_pkg::item_t noise_word();
    iptl_pkg::item_t w;
    w.op         = 1'($urandom_range(1));
    w.node_index = 16'($urandom);
    w.node_bytes = {$urandom, $urandom};
    w.addr_high  = {$urandom, $urandom};
    w.addr_low   = {$urandom, $urandom};
    return w;
  endfunction

  task automatic send_word(iptl_pkg::item_t w);
    start  <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (busy);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  task automatic write_node(bit [15:0] idx, bit [63:0] bytes);
    iptl_pkg::item_t w;
    w            = noise_word();
    w.op         = iptl_pkg::OpWrite;
    w.node_index = idx;
    w.node_bytes = bytes;
    send_word(w);
  endtask

  task automatic look_up(bit [63:0] hi, bit [63:0] lo);
    iptl_pkg::item_t w;
    w           = noise_word();
    w.op        = iptl_pkg::OpLookup;
    w.addr_high = hi;
    w.addr_low  = lo;
    send_word(w);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_access(logic [1:0] idx, logic wr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    logic [31:0] rd;
    reg_access(idx, 1'b1, val, rd);
    sb.set_reg(idx, val);
    reg_access(idx, 1'b0, '0, rd);
    if (rd !== val) sb.flag("register readback", 64'(val), 64'(rd));
  endtask

  task automatic set_config(bit [16:0] nc, bit [3:0] rb, bit [7:0] depth);
    settle();
    write_reg(iptl_pkg::RegTrieSize, 32'(nc));
    write_reg(iptl_pkg::RegRecordBytes, 32'(rb));
    write_reg(iptl_pkg::RegTreeDepth, 32'(depth));
    cur_nc = nc;
    cur_rb = rb;
  endtask

  task automatic run_phase(bit [16:0] nc, bit [3:0] rb, bit [7:0] depth, int unsigned idle,
                           int unsigned leaf_pct, int unsigned count, bit hold);
    int unsigned roll;
    set_config(nc, rb, depth);
    idle_pct   = idle;
    tree_nodes = (nc == 0) ? 1 : ((nc < 48) ? 32'(nc) : 48);
    // every reachable node is rewritten before the first lookup of the phase
    for (int unsigned i = 0; i < tree_nodes; i++)
      write_node(16'(i), pack_node(pick_child(leaf_pct), pick_child(leaf_pct)));
    for (int unsigned n = 0; n < count; n++) begin
      if (hold && n == count / 2) begin
        start <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end
      roll = $urandom_range(99);
      if (roll < 4) look_up('0, '0);
      else if (roll < 8) look_up('1, '1);
      else if (roll < 70) look_up({$urandom, $urandom}, {$urandom, $urandom});
      else if (roll < 88)
        write_node(16'($urandom_range(tree_nodes - 1)),
                   pack_node(pick_child(leaf_pct), pick_child(leaf_pct)));
      else write_node(16'($urandom_range(65535, tree_nodes)), {$urandom, $urandom});
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct = 0;

    // reset values, IPv6, 24-bit records: lowest and highest leaf at the root
    set_config(iptl_pkg::TrieSizeRst, iptl_pkg::RecordBytesRst, iptl_pkg::TreeDepthRst);
    write_node(16'd0, pack_node(32'd1, 32'h00FF_FFFF));
    look_up('0, '0);
    look_up('1, '1);

    // IPv4, 28-bit records, node 1 loops on itself
    set_config(17'd2, iptl_pkg::RecBytes28, 8'd32);
    write_node(16'd0, pack_node(32'd1, 32'h0FFF_FFFF));
    write_node(16'd1, pack_node(32'd2, 32'd1));
    look_up('1, 64'h0);
    look_up('0, 64'h7FFF_FFFF);
    look_up('0, 64'h8000_0000);

    // 32-bit records, three levels
    set_config(17'd3, iptl_pkg::RecBytes32, 8'd128);
    write_node(16'd0, pack_node(32'd1, 32'd2));
    write_node(16'd1, pack_node(32'hFFFF_FFFF, 32'd3));
    write_node(16'd2, pack_node(32'd1, 32'd0));
    look_up(64'h0, '0);
    look_up(64'h4000_0000_0000_0000, '0);
    look_up(64'hA000_0000_0000_0000, '1);

    // bad record sizes and zero depth: corrupt without a walk
    set_config(17'd1, '0, 8'd128);
    look_up('1, '1);
    set_config(17'd1, 4'(iptl_pkg::RecBytes24 - 1), 8'd128);
    look_up('0, '0);
    set_config(17'd1, 4'(iptl_pkg::RecBytes32 + 1), 8'd128);
    look_up('1, '0);
    set_config(17'd1, '1, 8'd128);
    look_up('0, '1);
    set_config(17'd1, iptl_pkg::RecBytes24, 8'd0);
    look_up('0, '0);

    // oversized depth acts as 128
    set_config(17'd1, iptl_pkg::RecBytes24, 8'd255);
    write_node(16'd0, pack_node(32'd0, 32'd1));
    look_up(64'h0400_0000_0000_0000, '1);

    // zero node count: the first record is always a leaf
    set_config(17'd0, iptl_pkg::RecBytes32, 8'd32);
    look_up('0, '0);
    look_up('1, '1);

    // pointer past the store reads as an all-zero node
    set_config(17'h1FFFF, iptl_pkg::RecBytes32, 8'd32);
    write_node(16'd0, pack_node(32'd70000, 32'h1FFFF + 32'd5));
    look_up('0, 64'h2000_0000);
    look_up('0, 64'h0);

    run_phase(17'd40,    iptl_pkg::RecBytes24, 8'd32,  0,  15, 150, 1'b0);
    run_phase(17'd65536, iptl_pkg::RecBytes32, 8'd128, 58, 10, 150, 1'b0);
    run_phase(17'd1000,  iptl_pkg::RecBytes28, 8'd128, 21, 8,  150, 1'b1);
    run_phase(17'd5,     iptl_pkg::RecBytes24, 8'd64,  58, 20, 120, 1'b0);
    run_phase(17'd16,    iptl_pkg::RecBytes32, 8'd32,  0,  4,  120, 1'b0);
    run_phase(17'd1,     iptl_pkg::RecBytes28, 8'd200, 21, 40, 110, 1'b0);

    settle();
    repeat (140) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[ip_prefix_trie_lookup] OK");
    end else begin
      $display("[ip_prefix_trie_lookup] ERROR");
    end
    $finish;
  end

endmodule

### ip_prefix_trie_lookup.f
rtl/core/iptl_pkg.sv
rtl/core/iptl_cfg_regs.sv
rtl/core/ip_prefix_trie_lookup.sv
verif/ip_prefix_trie_lookup_tb.sv
